/* hw/rtl/prem_pkg.sv */
// shared types, constants and helper functions for the peak/rms envelope meter
// no dependencies; used by prem_dp, prem_ctrl and peak_rms_envelope_meter
`default_nettype none

package prem_pkg;

    localparam int MAX_CHANNELS_DEF = 8;

    localparam int SAMPLE_W = 24;
    localparam int COEFF_W  = 25;
    localparam int PERIOD_W = 26;
    localparam int CNT_W    = 28;
    localparam int SQ_W     = 48;
    localparam int PROD_W   = 49;
    localparam int CFG_W    = 26;
    localparam int CFG_IDX_W = 2;

    localparam logic [COEFF_W-1:0]  COEFF_ONE  = 25'h100_0000;
    localparam logic [PERIOD_W-1:0] MIN_PERIOD = 26'd256;
    localparam logic signed [CNT_W-1:0] FRAME_STEP = 28'sd256;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd2;

    // reset values of the config registers
    localparam logic [COEFF_W-1:0]  ATTACK_RST  = 25'd4023;
    localparam logic [COEFF_W-1:0]  RELEASE_RST = 25'd4023;
    localparam logic [PERIOD_W-1:0] PERIOD_RST  = 26'd256;

    // square root takes one result bit, from two bits of radicand, per step
    localparam int ROOT_STEPS = 24;
    localparam int ITER_W     = 5;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ,
        OP_DIFF,
        OP_MPK,
        OP_MLO,
        OP_MHI,
        OP_UPD,
        OP_WR,
        OP_MAX,
        OP_FRAME,
        OP_ROOT,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic emit;
    } t_status;

    function automatic logic [COEFF_W-1:0] clamp_coeff(input logic [COEFF_W-1:0] c);
        return (c > COEFF_ONE) ? COEFF_ONE : c;
    endfunction

    // product >> 24, floored or rounded up
    function automatic logic [COEFF_W-1:0] scale_prod(input logic [PROD_W-1:0] p,
                                                      input logic round_up);
        logic [PROD_W:0] s;
        s = {1'b0, p} + (round_up ? 50'h0FF_FFFF : 50'd0);
        return s[48:24];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/prem_dp.sv */
// datapath of the envelope meter: config registers, envelopes, shared multiplier,
// frame maxima, update counter, bit-serial square root and output word; uses prem_pkg
`default_nettype none

module prem_dp import prem_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    input  wire logic signed [23:0]    i_sample,
    input  wire logic [2:0]            i_channel,
    input  wire logic                  i_last_channel,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    output logic [23:0]                o_peak_level,
    output logic [23:0]                o_rms_level
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [COEFF_W-1:0]  r_attack, r_release;
    logic [PERIOD_W-1:0] r_period;

    logic [SAMPLE_W-1:0] r_mag;
    logic [CH_W-1:0]     r_idx;
    logic                r_ch_ok, r_last;

    logic [PROD_W-1:0]   r_prod;
    logic                r_up_pk, r_up_sq;
    logic [SAMPLE_W-1:0] r_dpk, r_pe_old, r_step_pk, r_new_pe;
    logic [SQ_W-1:0]     r_dsq, r_se_old, r_step_sq, r_new_se;
    logic [COEFF_W-1:0]  r_frac_sq;

    logic [SAMPLE_W-1:0] r_peak_env [MAX_CHANNELS];
    logic [SQ_W-1:0]     r_sq_env   [MAX_CHANNELS];
    logic [SAMPLE_W-1:0] r_peak_max;
    logic [SQ_W-1:0]     r_sq_max;
    logic signed [CNT_W-1:0] r_cnt;

    logic [SQ_W-1:0]     r_rem, r_root, r_bit;
    logic [SAMPLE_W-1:0] r_peak_hold, r_peak_out, r_rms_out;

    logic [SAMPLE_W-1:0] mag;
    logic [COEFF_W-1:0]  c_pk, c_sq, mul_a;
    logic [SAMPLE_W-1:0] mul_b, pe_cur;
    logic [SQ_W-1:0]     se_cur, tsq, new_se, trial;
    logic [PERIOD_W-1:0] period;
    logic signed [CNT_W-1:0] cnt_dec, cnt_next;
    logic                emit;

    // full-scale negative wraps to 0x800000, which is the exact magnitude
    assign mag = i_sample[23] ? (24'd0 - i_sample) : i_sample;

    assign c_pk = r_up_pk ? clamp_coeff(r_attack) : clamp_coeff(r_release);
    assign c_sq = r_up_sq ? clamp_coeff(r_attack) : clamp_coeff(r_release);

    always_comb begin
        unique case (i_cmd.op)
            OP_SQ: begin
                mul_a = {1'b0, r_mag};
                mul_b = r_mag;
            end
            OP_MPK: begin
                mul_a = c_pk;
                mul_b = r_dpk;
            end
            OP_MLO: begin
                mul_a = c_sq;
                mul_b = r_dsq[23:0];
            end
            OP_MHI: begin
                mul_a = c_sq;
                mul_b = r_dsq[47:24];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign pe_cur = r_ch_ok ? r_peak_env[r_idx] : '0;
    assign se_cur = r_ch_ok ? r_sq_env[r_idx] : '0;
    assign tsq    = r_prod[SQ_W-1:0];
    assign new_se = r_up_sq ? (r_se_old + r_step_sq) : (r_se_old - r_step_sq);

    assign period   = (r_period < MIN_PERIOD) ? MIN_PERIOD : r_period;
    assign cnt_dec  = r_cnt - FRAME_STEP;
    assign emit     = cnt_dec[CNT_W-1] || (cnt_dec == '0);
    assign cnt_next = emit ? (cnt_dec + signed'({2'b00, period})) : cnt_dec;

    assign trial = r_root + r_bit;

    // state with reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack   <= ATTACK_RST;
            r_release  <= RELEASE_RST;
            r_period   <= PERIOD_RST;
            r_peak_max <= '0;
            r_sq_max   <= '0;
            r_cnt      <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_peak_env[i] <= '0;
                r_sq_env[i]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ATTACK:  r_attack  <= i_cfg_data[COEFF_W-1:0];
                    CFG_RELEASE: r_release <= i_cfg_data[COEFF_W-1:0];
                    CFG_PERIOD:  r_period  <= i_cfg_data[PERIOD_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_WR && r_ch_ok) begin
                r_peak_env[r_idx] <= r_new_pe;
                r_sq_env[r_idx]   <= new_se;
            end
            if (i_cmd.op == OP_MAX && r_ch_ok) begin
                if (r_new_pe > r_peak_max) begin
                    r_peak_max <= r_new_pe;
                end
                if (r_new_se > r_sq_max) begin
                    r_sq_max <= r_new_se;
                end
            end
            // frame maxima restart at every end of frame
            if (i_cmd.op == OP_FRAME && r_last) begin
                r_cnt      <= cnt_next;
                r_peak_max <= '0;
                r_sq_max   <= '0;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_mag   <= mag;
                r_idx   <= CH_W'(i_channel);
                r_ch_ok <= (int'(i_channel) < MAX_CHANNELS);
                r_last  <= i_last_channel;
            end
            OP_DIFF: begin
                r_pe_old <= pe_cur;
                r_se_old <= se_cur;
                r_up_pk  <= r_mag > pe_cur;
                r_up_sq  <= tsq > se_cur;
                r_dpk    <= (r_mag > pe_cur) ? (r_mag - pe_cur) : (pe_cur - r_mag);
                r_dsq    <= (tsq > se_cur) ? (tsq - se_cur) : (se_cur - tsq);
            end
            // a falling step rounds up so the envelope floors
            OP_MLO: r_step_pk <= SAMPLE_W'(scale_prod(r_prod, !r_up_pk));
            OP_MHI: r_frac_sq <= scale_prod(r_prod, !r_up_sq);
            OP_UPD: begin
                r_step_sq <= r_prod[SQ_W-1:0] + SQ_W'(r_frac_sq);
                r_new_pe  <= r_up_pk ? (r_pe_old + r_step_pk) : (r_pe_old - r_step_pk);
            end
            OP_WR: r_new_se <= new_se;
            OP_FRAME: begin
                if (r_last && emit) begin
                    r_rem       <= r_sq_max;
                    r_root      <= '0;
                    r_bit       <= 48'h4000_0000_0000;
                    r_peak_hold <= r_peak_max;
                end
            end
            OP_ROOT: begin
                if (r_rem >= trial) begin
                    r_rem  <= r_rem - trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_OUT: begin
                r_peak_out <= r_peak_hold;
                r_rms_out  <= r_root[SAMPLE_W-1:0];
            end
            default: ;
        endcase
    end

    assign o_status.last = r_last;
    assign o_status.emit = emit;
    assign o_peak_level  = r_peak_out;
    assign o_rms_level   = r_rms_out;

endmodule

`default_nettype wire

/* hw/rtl/prem_ctrl.sv */
// sequencer of the envelope meter: steps the datapath through one word and
// owns both handshakes; uses prem_pkg
`default_nettype none

module prem_ctrl import prem_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    output logic         o_valid,
    input  wire logic    i_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_DIFF,
        S_MPK,
        S_MLO,
        S_MHI,
        S_UPD,
        S_WR,
        S_MAX,
        S_FRAME,
        S_ROOT,
        S_OUT
    } t_state;

    t_state            r_state;
    logic              r_out_valid;
    logic [ITER_W-1:0] r_iter;
    logic              out_free;

    // output word leaves at this edge or is already gone
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_iter      <= '0;
        end else begin
            // a new word may replace the one leaving at this edge
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE:  if (i_valid) r_state <= S_SQ;
                S_SQ:    r_state <= S_DIFF;
                S_DIFF:  r_state <= S_MPK;
                S_MPK:   r_state <= S_MLO;
                S_MLO:   r_state <= S_MHI;
                S_MHI:   r_state <= S_UPD;
                S_UPD:   r_state <= S_WR;
                S_WR:    r_state <= S_MAX;
                S_MAX:   r_state <= S_FRAME;
                S_FRAME: begin
                    r_iter <= '0;
                    if (i_status.last && i_status.emit) begin
                        r_state <= S_ROOT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_ROOT: begin
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == ITER_W'(ROOT_STEPS - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:  o_cmd.op = i_valid ? OP_LOAD : OP_NONE;
            S_SQ:    o_cmd.op = OP_SQ;
            S_DIFF:  o_cmd.op = OP_DIFF;
            S_MPK:   o_cmd.op = OP_MPK;
            S_MLO:   o_cmd.op = OP_MLO;
            S_MHI:   o_cmd.op = OP_MHI;
            S_UPD:   o_cmd.op = OP_UPD;
            S_WR:    o_cmd.op = OP_WR;
            S_MAX:   o_cmd.op = OP_MAX;
            S_FRAME: o_cmd.op = OP_FRAME;
            S_ROOT:  o_cmd.op = OP_ROOT;
            S_OUT:   o_cmd.op = out_free ? OP_OUT : OP_NONE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && i_stall) |=> (r_state == S_OUT))
        else $error("result overwritten while output word pending");

    a_iter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT) |-> (r_iter < ITER_W'(ROOT_STEPS)))
        else $error("square root step count out of range");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> (r_state == S_SQ))
        else $error("accepted word did not start processing");

    a_no_emit_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRAME && !i_status.last) |=> (r_state == S_IDLE))
        else $error("result started without end of frame");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> r_out_valid)
        else $error("pending result dropped");

endmodule

`default_nettype wire

/* hw/rtl/peak_rms_envelope_meter.sv */
// each word steps the sequencer through LOAD, SQ, DIFF, MPK, MLO, MHI, UPD, WR, MAX
// and FRAME; a word that ends an update period goes on through ROOT (24 steps of the
// bit-serial square root) and OUT to o_valid; OUT waits while o_valid is held off
// no new word is taken until the last is done; four passes through the shared 25x24 multiplier
// reset (i_rst_n low, synchronous): envelopes, frame maxima and counter to zero,
// registers to their defaults, no result pending; no clearing pass
`default_nettype none

module peak_rms_envelope_meter import prem_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic signed [23:0]    i_sample,
    input  wire logic [2:0]            i_channel,
    input  wire logic                  i_last_channel,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [23:0]                o_peak_level,
    output logic [23:0]                o_rms_level,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    prem_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    prem_dp #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_sample       (i_sample),
        .i_channel      (i_channel),
        .i_last_channel (i_last_channel),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_peak_level   (o_peak_level),
        .o_rms_level    (o_rms_level)
    );

endmodule

`default_nettype wire
